// File: src/bffpa_pkg.sv
// Shared types and codes for the first-fit page allocator.
package bffpa_pkg;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOM = 2'd1,
        ST_OUT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SCAN_RD,
        S_SCAN_FEAT,
        S_SCAN_COMB,
        S_MARK_CHK,
        S_MARK_WR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic prep;
        logic rewind;
        logic advance;
        logic rd_en;
        logic feat_en;
        logic comb_en;
        logic mk_rd;
        logic mk_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic prep_fin;
        logic prep_mark;
        logic found;
        logic word_last;
        logic mk_hit;
        logic mk_done;
        logic out_busy;
    } t_sts;

endpackage

// File: src/bffpa_ctrl.sv
// Controller state machine of the first-fit page allocator.
module bffpa_ctrl import bffpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                if (i_sts.prep_fin) n_state = S_FIN;
                else if (i_sts.prep_mark) n_state = S_MARK_CHK;
                else n_state = S_SCAN_RD;
            end
            S_SCAN_RD:   n_state = S_SCAN_FEAT;
            S_SCAN_FEAT: n_state = S_SCAN_COMB;
            S_SCAN_COMB: begin
                if (i_sts.found) n_state = S_MARK_CHK;
                else if (i_sts.word_last) n_state = S_FIN;
                else n_state = S_SCAN_RD;
            end
            S_MARK_CHK: begin
                if (i_sts.mk_hit) n_state = S_MARK_WR;
                else if (i_sts.mk_done) n_state = S_FIN;
            end
            S_MARK_WR: begin
                if (i_sts.mk_done) n_state = S_FIN;
                else n_state = S_MARK_CHK;
            end
            S_FIN: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.advance = 1'b1;
            end
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_PREP: begin
                o_cmd.prep   = 1'b1;
                o_cmd.rewind = 1'b1;
            end
            S_SCAN_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_SCAN_FEAT: begin
                o_cmd.feat_en = 1'b1;
            end
            S_SCAN_COMB: begin
                o_cmd.comb_en = 1'b1;
                // restart the word sweep for marking once a run is found
                o_cmd.rewind  = i_sts.found;
                o_cmd.advance = !i_sts.found && !i_sts.word_last;
            end
            S_MARK_CHK: begin
                o_cmd.mk_rd   = i_sts.mk_hit;
                o_cmd.advance = !i_sts.mk_hit && !i_sts.mk_done;
            end
            S_MARK_WR: begin
                o_cmd.mk_wr   = 1'b1;
                o_cmd.advance = !i_sts.mk_done;
            end
            S_FIN: begin
                o_cmd.out_load = !i_sts.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: src/bffpa_dpath.sv
// Datapath of the first-fit page allocator: bitmap memory, scan and mark logic.
module bffpa_dpath import bffpa_pkg::*; #(
    parameter int TOTAL_PAGES = 1024,
    parameter int PAGE_SHIFT  = 12,
    parameter int WORD_BITS   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_wen,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_action,
    input  logic [31:0] i_size_bytes,
    input  logic [63:0] i_address,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic [63:0] o_run_address
);

    localparam int MW = (TOTAL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int XW = (MW > 1) ? $clog2(MW) : 1;
    localparam int PW = $clog2(TOTAL_PAGES + 1);
    localparam int IW = $clog2(TOTAL_PAGES);
    localparam int NW = 33 - PAGE_SHIFT;
    localparam int CW = NW + PW;
    localparam int OW = 64 - PAGE_SHIFT;
    localparam int BW = $clog2(WORD_BITS);
    localparam int TW = $clog2(WORD_BITS + 1);
    localparam int SW = PW + 2;

    localparam logic [XW-1:0] LAST_WORD = XW'(MW - 1);
    localparam logic [PW-1:0] TOTAL_P   = PW'(TOTAL_PAGES);
    localparam logic [PW-1:0] WORD_P    = PW'(WORD_BITS);
    localparam logic [32:0]   ROUND_ADD = 33'((64'(1) << PAGE_SHIFT) - 64'(1));

    function automatic logic [BW-1:0] oh_idx(input logic [WORD_BITS-1:0] oh);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (oh[i]) idx = idx | BW'(i);
        end
        return idx;
    endfunction

    logic [WORD_BITS-1:0] r_map [MW];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WORD_BITS-1:0] r_mask;

    logic [63:0]    r_base;
    logic           r_action;
    logic [NW-1:0]  r_need_raw;
    logic [OW-1:0]  r_ofs;
    logic [PW-1:0]  r_needc;
    logic [IW-1:0]  r_lo;
    logic [PW-1:0]  r_hi;
    t_status        r_code;
    logic           r_alloc_ok;
    logic [XW-1:0]  r_widx;
    logic [PW-1:0]  r_wbase;
    logic [TW-1:0]  r_t;
    logic [TW-1:0]  r_lead;
    logic           r_allfree;
    logic           r_mfound;
    logic [BW-1:0]  r_midx;
    logic [PW-1:0]  r_run;
    logic           r_ovalid;
    t_status        r_status;
    logic [63:0]    r_run_address;

    // request decode
    logic [32:0]    size_sum;
    logic [63:0]    addr_diff;
    logic [CW-1:0]  need_ext;
    logic           need_zero;
    logic           need_big;
    logic [PW-1:0]  needc;
    logic           ofs_out;
    logic [PW:0]    free_end;
    logic [PW-1:0]  hi_free;

    assign size_sum  = 33'(i_size_bytes) + ROUND_ADD;
    assign addr_diff = i_address - r_base;
    assign need_ext  = CW'(r_need_raw);
    assign need_zero = (r_need_raw == '0);
    assign need_big  = (need_ext > CW'(TOTAL_PAGES));
    assign needc     = need_big ? TOTAL_P : PW'(r_need_raw);
    assign ofs_out   = (r_ofs >= OW'(TOTAL_PAGES));
    assign free_end  = (PW+1)'(PW'(r_ofs)) + (PW+1)'(needc);
    // clip the freed run at the region end
    assign hi_free   = (free_end >= (PW+1)'(TOTAL_PAGES)) ? TOTAL_P : PW'(free_end);

    // word features for the scan
    logic [PW-1:0]        lim;
    logic [WORD_BITS-1:0] f;
    logic [WORD_BITS-1:0] frev;
    logic [WORD_BITS-1:0] z;
    logic [WORD_BITS-1:0] zr;
    logic [WORD_BITS-1:0] m;
    logic [TW-1:0]        t_cnt;
    logic [TW-1:0]        lead_cnt;

    assign lim = TOTAL_P - r_wbase;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            // pages past the region end count as used
            f[i] = ~r_rdata[i] & (PW'(i) < lim);
            frev[WORD_BITS-1-i] = f[i];
        end
    end

    assign z  = ~f;
    assign zr = ~frev;
    assign t_cnt    = (z == '0) ? TW'(WORD_BITS) : TW'(oh_idx(z & (~z + 1'b1)));
    assign lead_cnt = (zr == '0) ? TW'(WORD_BITS) : TW'(oh_idx(zr & (~zr + 1'b1)));

    always_comb begin
        logic [2*WORD_BITS-1:0] fp;
        logic [WORD_BITS-1:0]   term;
        fp = {{WORD_BITS{1'b0}}, f};
        for (int i = 0; i < WORD_BITS; i++) begin
            for (int k = 0; k < WORD_BITS; k++) begin
                term[k] = fp[i+k] | (PW'(k) >= r_needc);
            end
            m[i] = &term;
        end
    end

    // combine word features with the run carried in from lower words
    logic [PW:0]   sum_a;
    logic          hit_a;
    logic          found;
    logic [PW-1:0] start;

    assign sum_a = (PW+1)'(r_run) + (PW+1)'(r_t);
    assign hit_a = (sum_a >= (PW+1)'(r_needc));
    assign found = hit_a || r_mfound;
    assign start = hit_a ? (r_wbase - r_run) : (r_wbase + PW'(r_midx));

    // range mask for marking or clearing
    logic signed [SW-1:0] dlo;
    logic signed [SW-1:0] dhi;
    logic [WORD_BITS-1:0] mask;

    assign dlo = $signed(SW'(r_lo)) - $signed(SW'(r_wbase));
    assign dhi = $signed(SW'(r_hi)) - $signed(SW'(r_wbase));

    always_comb begin
        logic signed [SW-1:0] ii;
        for (int i = 0; i < WORD_BITS; i++) begin
            ii = $signed(SW'(i));
            mask[i] = (ii >= dlo) && (ii < dhi);
        end
    end

    logic                 mem_wr;
    logic                 mem_rd;
    logic [WORD_BITS-1:0] wdata;

    assign mem_wr = i_cmd.clr_wr | i_cmd.mk_wr;
    assign mem_rd = i_cmd.rd_en | i_cmd.mk_rd;
    assign wdata  = i_cmd.clr_wr ? '0 :
                    (r_action == ACT_ALLOC) ? (r_rdata | r_mask) : (r_rdata & ~r_mask);

    always_ff @(posedge i_clk) begin
        if (mem_wr) r_map[r_widx] <= wdata;
        if (mem_rd) r_rdata <= r_map[r_widx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_widx   <= '0;
            r_wbase  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wen) r_base <= i_cfg_wdata;
            if (i_cmd.rewind) begin
                r_widx  <= '0;
                r_wbase <= '0;
            end else if (i_cmd.advance) begin
                if (r_widx == LAST_WORD) begin
                    r_widx  <= '0;
                    r_wbase <= '0;
                end else begin
                    r_widx  <= r_widx + 1'b1;
                    r_wbase <= r_wbase + WORD_P;
                end
            end
            if (i_cmd.out_load) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_action;
            r_need_raw <= size_sum[32:PAGE_SHIFT];
            r_ofs      <= addr_diff[63:PAGE_SHIFT];
        end
        if (i_cmd.prep) begin
            r_needc    <= needc;
            r_run      <= '0;
            r_alloc_ok <= 1'b0;
            r_lo       <= IW'(r_ofs);
            r_hi       <= hi_free;
            if (r_action == ACT_ALLOC) r_code <= (need_zero || need_big) ? ST_OOM : ST_OK;
            else r_code <= ofs_out ? ST_OUT : ST_OK;
        end
        if (i_cmd.feat_en) begin
            r_t       <= t_cnt;
            r_lead    <= lead_cnt;
            r_allfree <= (z == '0);
            // a run longer than a word never fits inside one word
            r_mfound  <= (|m) && (r_needc <= WORD_P);
            r_midx    <= oh_idx(m & (~m + 1'b1));
        end
        if (i_cmd.comb_en) begin
            if (found) begin
                r_lo       <= IW'(start);
                r_hi       <= start + r_needc;
                r_alloc_ok <= 1'b1;
            end else begin
                if (r_widx == LAST_WORD) r_code <= ST_OOM;
                // extend the run through a free word, else restart at the top free bits
                r_run <= r_allfree ? (r_run + WORD_P) : PW'(r_lead);
            end
        end
        if (i_cmd.mk_rd) r_mask <= mask;
        if (i_cmd.out_load) begin
            r_status      <= r_code;
            r_run_address <= r_alloc_ok ? (r_base + (64'(r_lo) << PAGE_SHIFT)) : '0;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.clr_last  = (r_widx == LAST_WORD);
        o_sts.prep_fin  = (r_action == ACT_ALLOC) ? (need_zero || need_big)
                                                  : (ofs_out || need_zero);
        o_sts.prep_mark = (r_action == ACT_FREE) && !ofs_out && !need_zero;
        o_sts.found     = found;
        o_sts.word_last = (r_widx == LAST_WORD);
        o_sts.mk_hit    = |mask;
        o_sts.mk_done   = (dhi <= $signed(SW'(WORD_BITS))) || (r_widx == LAST_WORD);
        o_sts.out_busy  = r_ovalid && i_out_stall;
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_status;
    assign o_run_address = r_run_address;

endmodule

// File: src/bitmap_first_fit_page_allocator_unit.sv
// Top level of the bitmap first-fit contiguous page allocator.
// Keeps one used bit per page over TOTAL_PAGES pages of 2^PAGE_SHIFT bytes starting at
// region_base, held in a single-port memory of ceil(TOTAL_PAGES/WORD_BITS) words. After
// reset a clearing pass writes every bitmap word to zero, one word a cycle; no request
// is taken during it. A request takes one word per handshake and gives one result word.
// Each request passes a setup step; then an allocate scans words from the bottom, each
// through a read, word-features and run-combine step, until the run is found or the last
// word gives none, then marks by sweeping from word 0, checking each word and reading and
// rewriting each word that changes, up to the word holding the run end, and a final step
// loads the result. A free skips the scan. Zero-size or oversized allocates and frees
// outside the region or of zero size go straight from setup to loading the result. A new
// request is taken while the previous result still waits at the output.
module bitmap_first_fit_page_allocator_unit import bffpa_pkg::*; #(
    parameter int TOTAL_PAGES = 1024,
    parameter int PAGE_SHIFT  = 12,
    parameter int WORD_BITS   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [31:0] i_size_bytes,
    input  logic [63:0] i_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_run_address
);

    t_cmd w_cmd;
    t_sts w_sts;

    bffpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    bffpa_dpath #(
        .TOTAL_PAGES (TOTAL_PAGES),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .WORD_BITS   (WORD_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_action      (i_action),
        .i_size_bytes  (i_size_bytes),
        .i_address     (i_address),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_run_address (o_run_address)
    );

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_wr |-> o_in_stall)
        else $error("request accepted during bitmap clearing pass");

    a_result_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("result word appeared without a result load");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mk_wr |-> $past(w_cmd.mk_rd))
        else $error("bitmap mark write without a preceding word read");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3))
        else $error("undefined status code on the result");
`endif

endmodule
